FILE: sv/tcts_pkg.sv
// Shared types, constants and the semitone table of the two-channel tone sequencer.
package tcts_pkg;

    localparam int SCORE_DEPTH_DEF = 1024;
    localparam int NOTE_COUNT_DEF  = 72;
    localparam int LOOP_DEPTH_DEF  = 4;
    localparam int MAX_FETCH_DEF   = 64;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [7:0] ENV_DECAY_STEP = 8'd10;
    localparam logic [7:0] FULL_LEVEL     = 8'd255;

    typedef struct packed {
        logic [1:0] mode;
        logic       channel;
        logic [9:0] address;
        logic [7:0] data;
    } tcts_in_t;

    typedef struct packed {
        logic [1:0]  tone_action;
        logic [15:0] compare_value;
        logic [7:0]  volume;
        logic        fault;
    } tcts_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SERVICE,
        ST_CMD_REQ,
        ST_CMD_WAIT,
        ST_ARG_REQ,
        ST_ARG_WAIT,
        ST_CH_DONE,
        ST_FINISH,
        ST_OUT
    } tcts_state_t;

    function automatic logic [15:0] semitone(input logic [3:0] idx);
        logic [15:0] v;
        begin
            case (idx)
                4'd0:    v = 16'd38219;
                4'd1:    v = 16'd36074;
                4'd2:    v = 16'd34050;
                4'd3:    v = 16'd32141;
                4'd4:    v = 16'd30335;
                4'd5:    v = 16'd28633;
                4'd6:    v = 16'd27026;
                4'd7:    v = 16'd25509;
                4'd8:    v = 16'd24077;
                4'd9:    v = 16'd22726;
                4'd10:   v = 16'd21451;
                4'd11:   v = 16'd20247;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: sv/two_channel_tone_sequencer.sv
// Top level: score memory, per-channel state and the tick sequencer.
// Write and start beats give no result. A tick services channel 0, then channel 1, fetching
// at most MAX_FETCH score bytes per channel, then registers the result and raises out_valid.
// One beat at a time: no new beat is taken until the tick is done and its result is taken;
// score bytes are read one byte per read through the single read port of the score memory.
// Reset clears all channel state; score and loop stack are undefined until written.
module two_channel_tone_sequencer
    import tcts_pkg::*;
#(
    parameter int SCORE_DEPTH = SCORE_DEPTH_DEF,
    parameter int NOTE_COUNT  = NOTE_COUNT_DEF,
    parameter int LOOP_DEPTH  = LOOP_DEPTH_DEF,
    parameter int MAX_FETCH   = MAX_FETCH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tcts_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output tcts_out_t out_data
);

    localparam int AW = $clog2(SCORE_DEPTH);
    localparam int SW = $clog2(LOOP_DEPTH + 1);
    localparam int LW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int FW = $clog2(MAX_FETCH + 1);
    localparam logic [7:0] NOTE_C = 8'(NOTE_COUNT);
    localparam logic [7:0] OP_END = 8'(NOTE_COUNT + 1);
    localparam logic [7:0] OP_TEMPO = 8'(NOTE_COUNT + 2);
    localparam logic [7:0] OP_VOL = 8'(NOTE_COUNT + 3);
    localparam logic [7:0] OP_LST = 8'(NOTE_COUNT + 4);
    localparam logic [7:0] OP_LEND = 8'(NOTE_COUNT + 5);
    localparam logic [7:0] OP_STR = 8'(NOTE_COUNT + 6);
    localparam logic [7:0] OP_ATR = 8'(NOTE_COUNT + 7);

    // Score memory, one synchronous read port.
    logic [7:0] score_mem [SCORE_DEPTH];
    logic [AW-1:0] rd_addr;
    logic       rd_en;
    logic [7:0] rd_data_reg;

    // Loop stack memories, one per channel row; small and addressed at top.
    logic [AW-1:0] loop_addr_mem [2][LOOP_DEPTH];
    logic [7:0]    loop_cnt_mem  [2][LOOP_DEPTH];

    logic          active_reg [2];
    logic [AW-1:0] ptr_reg [2];
    logic [7:0]    len_reg [2];
    logic [7:0]    tempo_reg [2];
    logic [7:0]    acc_reg [2];
    logic [7:0]    tr_reg [2];
    logic [7:0]    mvol_reg [2];
    logic [7:0]    env_reg [2];
    logic [7:0]    decay_reg [2];
    logic [7:0]    thr_reg [2];
    logic [6:0]    note_reg [2];
    logic          trig_reg [2];
    logic [SW-1:0] top_reg [2];

    tcts_state_t state_reg, state_next;
    logic        ch_reg;
    logic [7:0]  cmd_reg;
    logic [FW-1:0] used_reg;
    logic [7:0]  v0_reg, v1_reg;
    logic        a0_reg, a1_reg;
    logic        fault_reg;
    logic        out_valid_reg;
    tcts_out_t   out_reg;

    logic        c;
    logic [LW-1:0] tidx;
    assign c = ch_reg;
    assign tidx = LW'(top_reg[c] - SW'(1));

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic accept;
    assign accept = in_valid && in_ready;

    // Combinational helpers for the current channel.
    logic [15:0] vol_prod;
    logic [7:0]  env_dec;
    logic [8:0]  tsum;
    logic signed [9:0] tnote;
    logic [6:0]  tnote_sat;
    logic        need_arg;
    assign env_dec = (env_reg[c] > decay_reg[c]) ? env_reg[c] - decay_reg[c] : 8'd0;
    assign tsum = {1'b0, acc_reg[c]} + {1'b0, tempo_reg[c]} + 9'd1;
    assign tnote = $signed({2'b00, cmd_reg}) + $signed({{2{tr_reg[c][7]}}, tr_reg[c]});
    assign tnote_sat = (tnote < 0) ? 7'd0 :
                       (tnote > 10'(NOTE_COUNT - 1)) ? 7'(NOTE_COUNT - 1) : 7'(tnote);
    assign need_arg = (cmd_reg <= NOTE_C) || (cmd_reg == OP_TEMPO) || (cmd_reg == OP_VOL) ||
                      (cmd_reg == OP_LST) || (cmd_reg == OP_STR) || (cmd_reg == OP_ATR);

    logic [7:0] cur_env;
    logic       decay_now;
    assign decay_now = (decay_reg[c] != 8'd0) && (len_reg[c] < thr_reg[c]);
    assign cur_env   = decay_now ? env_dec : env_reg[c];
    assign vol_prod  = mvol_reg[c] * ({1'b0, cur_env} + 9'd1);

    // Output assembly.
    logic        o_trg;
    logic [6:0]  o_idx;
    logic [7:0]  o_vol;
    logic [3:0]  o_semi;
    logic [2:0]  o_oct;
    logic [12:0] o_mul;
    logic [6:0]  o_rem;
    tcts_out_t   o_word;
    always_comb
    begin
        o_trg = 1'b0;
        o_idx = 7'(NOTE_COUNT);
        o_vol = 8'd0;
        if (a0_reg)
        begin
            o_trg = trig_reg[0];
            o_vol = v0_reg;
            o_idx = note_reg[0];
        end
        if (a1_reg)
        begin
            o_trg = trig_reg[1];
            o_vol = v1_reg;
            o_idx = note_reg[1];
        end
        // Octave by multiplying with 43/512, exact for every note number below 96.
        o_mul  = 13'(o_idx) * 13'd43;
        o_oct  = o_mul[11:9];
        o_rem  = o_idx - 7'({o_oct, 3'b000}) - 7'({o_oct, 2'b00});
        o_semi = o_rem[3:0];
        o_word.tone_action   = ACT_NONE;
        o_word.compare_value = 16'd0;
        o_word.volume        = o_vol;
        o_word.fault         = fault_reg;
        if (o_trg)
        begin
            if (o_idx < 7'(NOTE_COUNT))
            begin
                o_word.tone_action   = ACT_START;
                o_word.compare_value = (semitone(o_semi) >> o_oct) - 16'd1;
            end
            else
            begin
                o_word.tone_action = ACT_STOP;
            end
        end
        else if (a0_reg && a1_reg)
        begin
            o_word.tone_action = ACT_STOP;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        rd_en = 1'b0;
        rd_addr = ptr_reg[c];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.mode == MODE_TICK)
                begin
                    state_next = ST_SERVICE;
                end
            end
            ST_SERVICE:
            begin
                if (len_reg[c] != 8'd0 || !active_reg[c])
                begin
                    state_next = ST_CH_DONE;
                end
                else
                begin
                    state_next = ST_CMD_REQ;
                end
            end
            ST_CMD_REQ:
            begin
                if (!active_reg[c])
                begin
                    state_next = ST_CH_DONE;
                end
                else if (used_reg >= FW'(MAX_FETCH))
                begin
                    state_next = ST_CH_DONE;
                end
                else
                begin
                    rd_en = 1'b1;
                    state_next = ST_CMD_WAIT;
                end
            end
            ST_CMD_WAIT:
            begin
                state_next = ST_ARG_REQ;
            end
            ST_ARG_REQ:
            begin
                if (!need_arg)
                begin
                    state_next = (cmd_reg == OP_END) ? ST_CH_DONE : ST_CMD_REQ;
                end
                else if (used_reg >= FW'(MAX_FETCH))
                begin
                    state_next = ST_CH_DONE;
                end
                else
                begin
                    rd_en = 1'b1;
                    state_next = ST_ARG_WAIT;
                end
            end
            ST_ARG_WAIT:
            begin
                state_next = (cmd_reg <= NOTE_C) ? ST_CH_DONE : ST_CMD_REQ;
            end
            ST_CH_DONE:
            begin
                state_next = c ? ST_FINISH : ST_SERVICE;
            end
            ST_FINISH:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Score memory: write on write beats, read on fetch.
    always_ff @(posedge clk)
    begin
        if (accept && in_data.mode == MODE_WRITE)
        begin
            score_mem[AW'(in_data.address)] <= in_data.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= score_mem[rd_addr];
        end
    end

    // Channel state and the sequencer datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                active_reg[i] <= 1'b0;
                ptr_reg[i]    <= '0;
                len_reg[i]    <= '0;
                tempo_reg[i]  <= '0;
                acc_reg[i]    <= '0;
                tr_reg[i]     <= '0;
                mvol_reg[i]   <= '0;
                env_reg[i]    <= '0;
                decay_reg[i]  <= '0;
                thr_reg[i]    <= '0;
                note_reg[i]   <= '0;
                trig_reg[i]   <= 1'b0;
                top_reg[i]    <= '0;
            end
            ch_reg        <= 1'b0;
            cmd_reg       <= '0;
            used_reg      <= '0;
            v0_reg        <= '0;
            v1_reg        <= '0;
            a0_reg        <= 1'b0;
            a1_reg        <= 1'b0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && in_data.mode == MODE_START)
                    begin
                        active_reg[in_data.channel] <= 1'b1;
                        ptr_reg[in_data.channel]    <= AW'(in_data.address);
                        len_reg[in_data.channel]    <= '0;
                        tr_reg[in_data.channel]     <= '0;
                        acc_reg[in_data.channel]    <= '0;
                        tempo_reg[in_data.channel]  <= FULL_LEVEL;
                        mvol_reg[in_data.channel]   <= FULL_LEVEL;
                    end
                    if (accept && in_data.mode == MODE_TICK)
                    begin
                        ch_reg    <= 1'b0;
                        fault_reg <= 1'b0;
                        a0_reg    <= active_reg[0];
                        a1_reg    <= active_reg[1];
                    end
                end
                ST_SERVICE:
                begin
                    used_reg <= '0;
                    env_reg[c] <= cur_env;
                    if (c)
                    begin
                        v1_reg <= vol_prod[15:8];
                    end
                    else
                    begin
                        v0_reg <= vol_prod[15:8];
                    end
                    if (len_reg[c] != 8'd0)
                    begin
                        if (tsum[8])
                        begin
                            len_reg[c] <= len_reg[c] - 8'd1;
                        end
                        acc_reg[c]  <= tsum[7:0];
                        trig_reg[c] <= 1'b0;
                    end
                end
                ST_CMD_REQ:
                begin
                    if (active_reg[c])
                    begin
                        if (used_reg >= FW'(MAX_FETCH))
                        begin
                            active_reg[c] <= 1'b0;
                            note_reg[c]   <= 7'(NOTE_COUNT);
                            trig_reg[c]   <= 1'b1;
                            fault_reg     <= 1'b1;
                        end
                        else
                        begin
                            used_reg <= used_reg + FW'(1);
                            ptr_reg[c] <= ptr_reg[c] + AW'(1);
                        end
                    end
                end
                ST_CMD_WAIT:
                begin
                    cmd_reg <= rd_data_reg;
                end
                ST_ARG_REQ:
                begin
                    if (!need_arg)
                    begin
                        if (cmd_reg == OP_END)
                        begin
                            active_reg[c] <= 1'b0;
                            note_reg[c]   <= 7'(NOTE_COUNT);
                            trig_reg[c]   <= 1'b1;
                        end
                        else if (cmd_reg == OP_LEND && top_reg[c] != '0)
                        begin
                            if (loop_cnt_mem[c][tidx] != 8'd1)
                            begin
                                loop_cnt_mem[c][tidx] <= loop_cnt_mem[c][tidx] - 8'd1;
                                ptr_reg[c] <= loop_addr_mem[c][tidx];
                            end
                            else
                            begin
                                top_reg[c] <= top_reg[c] - SW'(1);
                            end
                        end
                    end
                    else if (used_reg >= FW'(MAX_FETCH))
                    begin
                        active_reg[c] <= 1'b0;
                        note_reg[c]   <= 7'(NOTE_COUNT);
                        trig_reg[c]   <= 1'b1;
                        fault_reg     <= 1'b1;
                    end
                    else
                    begin
                        used_reg <= used_reg + FW'(1);
                        ptr_reg[c] <= ptr_reg[c] + AW'(1);
                    end
                end
                ST_ARG_WAIT:
                begin
                    if (cmd_reg <= NOTE_C)
                    begin
                        len_reg[c]   <= rd_data_reg - 8'd1;
                        trig_reg[c]  <= 1'b1;
                        thr_reg[c]   <= {1'b0, rd_data_reg[7:1]};
                        decay_reg[c] <= ENV_DECAY_STEP;
                        if (cmd_reg < NOTE_C)
                        begin
                            note_reg[c] <= tnote_sat;
                            env_reg[c]  <= FULL_LEVEL;
                        end
                        else
                        begin
                            note_reg[c] <= 7'(NOTE_COUNT);
                            env_reg[c]  <= 8'd0;
                        end
                    end
                    else if (cmd_reg == OP_TEMPO)
                    begin
                        tempo_reg[c] <= rd_data_reg;
                    end
                    else if (cmd_reg == OP_VOL)
                    begin
                        mvol_reg[c] <= rd_data_reg;
                    end
                    else if (cmd_reg == OP_STR)
                    begin
                        tr_reg[c] <= rd_data_reg;
                    end
                    else if (cmd_reg == OP_ATR)
                    begin
                        tr_reg[c] <= tr_reg[c] + rd_data_reg;
                    end
                    else if (top_reg[c] < SW'(LOOP_DEPTH))
                    begin
                        loop_addr_mem[c][LW'(top_reg[c])] <= ptr_reg[c];
                        loop_cnt_mem[c][LW'(top_reg[c])]  <= rd_data_reg;
                        top_reg[c] <= top_reg[c] + SW'(1);
                    end
                end
                ST_CH_DONE:
                begin
                    ch_reg <= 1'b1;
                end
                ST_FINISH:
                begin
                    out_reg <= o_word;
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result lost while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken during tick service");
    a_fetch_limit: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FW'(MAX_FETCH))
        else $error("fetch count beyond limit");
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg[0] <= SW'(LOOP_DEPTH) && top_reg[1] <= SW'(LOOP_DEPTH))
        else $error("loop stack overflow");
`endif

endmodule

FILE: sim/tb_two_channel_tone_sequencer.sv
// Testbench of the two-channel tone sequencer: directed table, random scores, self-checking.
module tb_two_channel_tone_sequencer;
    import tcts_pkg::*;

    localparam int NOTES     = NOTE_COUNT_DEF;
    localparam int STACK_MAX = LOOP_DEPTH_DEF;
    localparam int FETCH_MAX = MAX_FETCH_DEF;
    localparam int ITEM_GOAL = 1150;

    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam bit [7:0] OP_REST       = 8'(NOTES);
    localparam bit [7:0] OP_END        = 8'(NOTES + 1);
    localparam bit [7:0] OP_TEMPO      = 8'(NOTES + 2);
    localparam bit [7:0] OP_VOLUME     = 8'(NOTES + 3);
    localparam bit [7:0] OP_LOOP_START = 8'(NOTES + 4);
    localparam bit [7:0] OP_LOOP_END   = 8'(NOTES + 5);
    localparam bit [7:0] OP_SET_TR     = 8'(NOTES + 6);
    localparam bit [7:0] OP_ADD_TR     = 8'(NOTES + 7);

    localparam bit [15:0] TONE_PERIOD [12] = '{
        16'd38219, 16'd36074, 16'd34050, 16'd32141, 16'd30335, 16'd28633,
        16'd27026, 16'd25509, 16'd24077, 16'd22726, 16'd21451, 16'd20247
    };

    typedef struct {
        bit       active [2];
        bit [9:0] rp     [2];
        bit [7:0] len    [2];
        bit [7:0] tempo  [2];
        bit [7:0] acc    [2];
        bit [7:0] tr     [2];
        bit [7:0] mvol   [2];
        bit [7:0] env    [2];
        bit [7:0] decay  [2];
        bit [7:0] thr    [2];
        bit [7:0] note   [2];
        bit       trig   [2];
        bit [9:0] laddr  [2][STACK_MAX];
        bit [7:0] lcount [2][STACK_MAX];
        int       top    [2];
    } player_state_t;

    typedef struct {
        tcts_in_t  beat;
        bit        typed;
        tcts_out_t want;
    } table_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    tcts_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    tcts_out_t out_data;

    player_state_t player;
    bit [7:0]      score    [1024];
    bit            written  [1024];
    tcts_out_t     tone_queue [$];
    int            error_count;
    int            beat_count;
    bit            quiet_phase;
    int            stall_left;

    two_channel_tone_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #60000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic bit fetch_byte(inout player_state_t s, input int c, inout int used,
                                      inout bit [1:0] miss, output bit [7:0] b);
        if (used >= FETCH_MAX)
            return 1'b0;
        used++;
        if (!written[s.rp[c]])
            miss[c] = 1'b1;
        b = score[s.rp[c]];
        s.rp[c] = s.rp[c] + 10'd1;
        return 1'b1;
    endfunction

    function automatic void halt_channel(inout player_state_t s, input int c);
        s.active[c] = 1'b0;
        s.note[c]   = OP_REST;
        s.trig[c]   = 1'b1;
    endfunction

    function automatic bit [7:0] play_channel(inout player_state_t s, input int c,
                                              inout bit fault, inout bit [1:0] miss);
        int        used;
        bit [7:0]  cmd;
        bit [7:0]  arg;
        bit [7:0]  vol;
        bit [16:0] prod;
        bit [8:0]  sum;
        int        n;
        int        t;
        used = 0;
        if (s.decay[c] != 0 && s.len[c] < s.thr[c])
            s.env[c] = (s.env[c] > s.decay[c]) ? s.env[c] - s.decay[c] : 8'd0;
        prod = s.mvol[c] * ({1'b0, s.env[c]} + 9'd1);
        vol = prod[15:8];
        if (s.len[c] != 0)
        begin
            sum = s.acc[c] + s.tempo[c] + 9'd1;
            if (sum[8])
                s.len[c]--;
            s.acc[c] = sum[7:0];
            s.trig[c] = 1'b0;
            return vol;
        end
        while (s.active[c])
        begin
            if (!fetch_byte(s, c, used, miss, cmd))
            begin
                halt_channel(s, c);
                fault = 1'b1;
                return vol;
            end
            if (cmd <= OP_REST)
            begin
                if (!fetch_byte(s, c, used, miss, arg))
                begin
                    halt_channel(s, c);
                    fault = 1'b1;
                    return vol;
                end
                s.len[c] = arg - 8'd1;
                if (cmd < OP_REST)
                begin
                    n = int'(cmd) + int'($signed(s.tr[c]));
                    if (n < 0)
                        n = 0;
                    if (n > NOTES - 1)
                        n = NOTES - 1;
                    s.note[c] = n[7:0];
                    s.env[c] = 8'd255;
                end
                else
                begin
                    s.note[c] = OP_REST;
                    s.env[c] = 8'd0;
                end
                s.trig[c] = 1'b1;
                s.thr[c] = arg >> 1;
                s.decay[c] = 8'd10;
                return vol;
            end
            else if (cmd == OP_END)
            begin
                halt_channel(s, c);
                return vol;
            end
            else if (cmd == OP_TEMPO || cmd == OP_VOLUME || cmd == OP_LOOP_START ||
                     cmd == OP_SET_TR || cmd == OP_ADD_TR)
            begin
                if (!fetch_byte(s, c, used, miss, arg))
                begin
                    halt_channel(s, c);
                    fault = 1'b1;
                    return vol;
                end
                if (cmd == OP_TEMPO)
                    s.tempo[c] = arg;
                else if (cmd == OP_VOLUME)
                    s.mvol[c] = arg;
                else if (cmd == OP_SET_TR)
                    s.tr[c] = arg;
                else if (cmd == OP_ADD_TR)
                    s.tr[c] = s.tr[c] + arg;
                else if (s.top[c] < STACK_MAX)
                begin
                    s.laddr[c][s.top[c]] = s.rp[c];
                    s.lcount[c][s.top[c]] = arg;
                    s.top[c]++;
                end
            end
            else if (cmd == OP_LOOP_END && s.top[c] > 0)
            begin
                t = s.top[c] - 1;
                if (s.lcount[c][t] - 8'd1 != 8'd0)
                begin
                    s.lcount[c][t] = s.lcount[c][t] - 8'd1;
                    s.rp[c] = s.laddr[c][t];
                end
                else
                    s.top[c] = t;
            end
        end
        return vol;
    endfunction

    // Works out the tone command of one tick; miss flags channels that would read unwritten score.
    function automatic tcts_out_t tick_tone(inout player_state_t s, output bit [1:0] miss);
        tcts_out_t o;
        bit        a0;
        bit        a1;
        bit        fault;
        bit        trg;
        bit [7:0]  v0;
        bit [7:0]  v1;
        bit [7:0]  vol;
        bit [7:0]  idx;
        bit [15:0] period;
        miss = 2'b00;
        fault = 1'b0;
        trg = 1'b0;
        vol = 8'd0;
        idx = OP_REST;
        a0 = s.active[0];
        a1 = s.active[1];
        v0 = play_channel(s, 0, fault, miss);
        v1 = play_channel(s, 1, fault, miss);
        if (a0)
        begin
            trg = s.trig[0];
            vol = v0;
            idx = s.note[0];
        end
        if (a1)
        begin
            trg = s.trig[1];
            vol = v1;
            idx = s.note[1];
        end
        o = '0;
        if (trg)
        begin
            if (idx < NOTES)
            begin
                period = TONE_PERIOD[idx % 12];
                o.tone_action = ACT_START;
                o.compare_value = (period >> (idx / 12)) - 16'd1;
            end
            else
                o.tone_action = ACT_STOP;
        end
        else if (a0 && a1)
            o.tone_action = ACT_STOP;
        else
            o.tone_action = ACT_NONE;
        o.volume = vol;
        o.fault = fault;
        return o;
    endfunction

    // Advances the player by one accepted beat and returns whether a tone result follows.
    function automatic bit advance_player(input tcts_in_t b, output tcts_out_t o);
        bit [1:0] miss;
        o = '0;
        case (b.mode)
            MODE_WRITE:
            begin
                score[b.address] = b.data;
                written[b.address] = 1'b1;
                return 1'b0;
            end
            MODE_START:
            begin
                player.active[b.channel] = 1'b1;
                player.rp[b.channel] = b.address;
                player.len[b.channel] = 8'd0;
                player.tr[b.channel] = 8'd0;
                player.acc[b.channel] = 8'd0;
                player.tempo[b.channel] = 8'd255;
                player.mvol[b.channel] = 8'd255;
                return 1'b0;
            end
            MODE_TICK:
            begin
                o = tick_tone(player, miss);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(input tcts_in_t b, input bit typed, input tcts_out_t want);
        int        gap;
        tcts_out_t tone;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (advance_player(b, tone))
            tone_queue.push_back(typed ? want : tone);
        if (b.mode != MODE_IGNORED)
            beat_count++;
    endtask

    task automatic send(input logic [1:0] mode, input bit ch, input bit [9:0] addr,
                        input bit [7:0] data);
        tcts_in_t b;
        b.mode = mode;
        b.channel = ch;
        b.address = addr;
        b.data = data;
        send_beat(b, 1'b0, '0);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet_phase && $urandom_range(0, 99) < 25)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                       : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        tcts_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tone_queue.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                want = tone_queue.pop_front();
                if (out_data.tone_action != want.tone_action)
                    report("tone_action", int'(out_data.tone_action),
                           int'(want.tone_action));
                if (out_data.compare_value != want.compare_value)
                    report("compare_value", int'(out_data.compare_value),
                           int'(want.compare_value));
                if (out_data.volume != want.volume)
                    report("volume", int'(out_data.volume), int'(want.volume));
                if (out_data.fault != want.fault)
                    report("fault", int'(out_data.fault), int'(want.fault));
            end
        end
    end

    bit [7:0] seg_bytes [$];
    int       seg_starts [$];
    int       alloc_ptr;

    function automatic bit [7:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(1, 6));
    endfunction

    // Builds one random score fragment that always ends at END.
    task automatic build_fragment();
        int k;
        int count;
        seg_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            count = $urandom_range(30, 36);
            for (k = 0; k < count; k++)
            begin
                seg_bytes.push_back(($urandom_range(0, 1) != 0) ? OP_VOLUME : OP_TEMPO);
                seg_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        count = $urandom_range(2, 8);
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    seg_bytes.push_back(8'($urandom_range(0, NOTES)));
                    seg_bytes.push_back(pick_length());
                end
                3: begin seg_bytes.push_back(OP_TEMPO); seg_bytes.push_back(8'($urandom)); end
                4: begin seg_bytes.push_back(OP_VOLUME); seg_bytes.push_back(8'($urandom)); end
                5:
                begin
                    seg_bytes.push_back(OP_LOOP_START);
                    seg_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'd0
                                                                     : 8'($urandom_range(1, 3)));
                end
                6: seg_bytes.push_back(OP_LOOP_END);
                7: begin seg_bytes.push_back(OP_SET_TR); seg_bytes.push_back(8'($urandom)); end
                8: begin seg_bytes.push_back(OP_ADD_TR); seg_bytes.push_back(8'($urandom)); end
                default: seg_bytes.push_back(8'($urandom_range(int'(OP_ADD_TR) + 1, 255)));
            endcase
        end
        seg_bytes.push_back(OP_END);
    endtask

    task automatic load_fragment();
        build_fragment();
        if (alloc_ptr + seg_bytes.size() > 1024)
            alloc_ptr = 0;
        seg_starts.push_back(alloc_ptr);
        foreach (seg_bytes[k])
            send(MODE_WRITE, 1'b0, 10'(alloc_ptr + k), seg_bytes[k]);
        alloc_ptr += seg_bytes.size();
    endtask

    task automatic safe_tick();
        player_state_t trial;
        bit [1:0]      miss;
        trial = player;
        void'(tick_tone(trial, miss));
        // A channel that would run into unwritten score is sent to the newest fragment.
        while (miss != 2'b00)
        begin
            send(MODE_START, miss[1], 10'(seg_starts[seg_starts.size() - 1]), 8'd0);
            trial = player;
            void'(tick_tone(trial, miss));
        end
        send(MODE_TICK, 1'($urandom), 10'($urandom), 8'($urandom));
    endtask

    table_row_t directed [$];

    function automatic table_row_t row(input logic [1:0] mode, input bit ch,
                                       input bit [9:0] addr, input bit [7:0] data);
        table_row_t r;
        r.beat.mode = mode;
        r.beat.channel = ch;
        r.beat.address = addr;
        r.beat.data = data;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    initial
    begin
        table_row_t r;
        int         k;
        int         pick;
        bit         drained;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        error_count = 0;
        beat_count = 0;
        quiet_phase = 1'b0;
        stall_left = 0;
        alloc_ptr = 16;
        drained = 1'b0;

        // Idle tick: nothing playing, so every field is zero.
        r = row(MODE_TICK, 1'b1, 10'd1023, 8'd255);
        r.typed = 1'b1;
        r.want = '{tone_action: ACT_NONE, compare_value: 16'd0, volume: 8'd0, fault: 1'b0};
        directed.push_back(r);
        directed.push_back(row(MODE_IGNORED, 1'b1, 10'd1023, 8'd255));
        // Transpose of -128 saturates the note at the bottom of the table.
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd0, OP_SET_TR));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd1, 8'd128));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd2, 8'd5));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd3, 8'd1));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd4, OP_SET_TR));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd5, 8'd127));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd6, 8'(NOTES - 1)));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd7, 8'd0));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd8, 8'd255));
        directed.push_back(row(MODE_WRITE, 1'b0, 10'd9, OP_END));
        // Loop end on an empty stack at the top address, then the pointer wraps to zero.
        directed.push_back(row(MODE_WRITE, 1'b1, 10'd1023, OP_LOOP_END));
        directed.push_back(row(MODE_START, 1'b0, 10'd0, 8'd0));
        r = row(MODE_TICK, 1'b0, 10'd0, 8'd0);
        r.typed = 1'b1;
        r.want = '{tone_action: ACT_START, compare_value: 16'd38218, volume: 8'd0, fault: 1'b0};
        directed.push_back(r);
        directed.push_back(row(MODE_TICK, 1'b0, 10'd0, 8'd0));
        directed.push_back(row(MODE_START, 1'b1, 10'd1023, 8'd0));
        for (k = 0; k < 6; k++)
            directed.push_back(row(MODE_TICK, 1'b0, 10'd0, 8'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_beat(directed[k].beat, directed[k].typed, directed[k].want);

        load_fragment();
        while (beat_count < ITEM_GOAL)
        begin
            if (beat_count % 150 < 20)
                quiet_phase = 1'b1;
            else
                quiet_phase = 1'b0;
            if (!drained && beat_count > ITEM_GOAL / 2)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                wait (tone_queue.size() == 0);
                @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                load_fragment();
            else if (pick < 20)
                send(MODE_START, 1'($urandom),
                     10'(seg_starts[$urandom_range(0, seg_starts.size() - 1)]), 8'($urandom));
            else if (pick < 22)
                send(MODE_IGNORED, 1'($urandom), 10'($urandom), 8'($urandom));
            else
                safe_tick();
        end
        in_valid <= 1'b0;

        wait (tone_queue.size() == 0);
        repeat (500) @(posedge clk);
        if (error_count == 0 && tone_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: two_channel_tone_sequencer.f
sv/tcts_pkg.sv
sv/two_channel_tone_sequencer.sv
sim/tb_two_channel_tone_sequencer.sv
